// ===== hw/rtl/mmss_countdown_timer_controller_core_defines.svh =====
// assertion macros for the timer controller core rtl
`ifndef MMSS_COUNTDOWN_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define MMSS_COUNTDOWN_TIMER_CONTROLLER_CORE_DEFINES_SVH

// consequence must hold in the same cycle as the trigger
`define MCDT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the trigger
`define MCDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mcdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcdt_pkg;

   // digit limits
   localparam logic [3:0] TENS_MAX  = 4'd5;
   localparam logic [3:0] UNITS_MAX = 4'd9;

   // csr reset values
   localparam logic [15:0] TPS_RESET         = 16'd1000;
   localparam logic [23:0] IDLE_RESET        = 24'd60000;
   localparam logic [23:0] ALARM_IV_RESET    = 24'd500;
   localparam logic [15:0] ALARM_LIMIT_RESET = 16'd120;

   localparam logic [1:0] CURSOR_RESET = 2'd2;
   localparam logic [1:0] CURSOR_MAX   = 2'd3;

   // button bit positions
   localparam int BTN_RIGHT  = 0;
   localparam int BTN_LEFT   = 1;
   localparam int BTN_UP     = 2;
   localparam int BTN_DOWN   = 3;
   localparam int BTN_CENTER = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TICKS_PER_SECOND     = 2'd0,
      CSR_IDLE_POWERDOWN_TICKS = 2'd1,
      CSR_ALARM_INTERVAL_TICKS = 2'd2,
      CSR_ALARM_LIMIT          = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_COUNT = 2'd1,
      MODE_ALARM = 2'd2,
      MODE_DOWN  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] ticks_per_second;
      logic [23:0] idle_powerdown_ticks;
      logic [23:0] alarm_interval_ticks;
      logic [15:0] alarm_limit;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [4:0] buttons;
   } req_type;

   typedef struct packed {
      logic [3:0] sec_units;
      logic [2:0] sec_tens;
      logic [3:0] min_units;
      logic [2:0] min_tens;
      logic [1:0] cursor_pos;
      logic       cursor_shown;
      logic [1:0] mode;
      logic       alarm_flag;
      logic       alarm_sound;
   } rsp_type;

   // odd positions are tens digits
   function automatic logic [3:0] digit_limit(input logic [1:0] pos);
      return pos[0] ? TENS_MAX : UNITS_MAX;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcdt_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcdt_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [mcdt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcdt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mcdt_pkg::cfg_type                       cfg
);

   mcdt_pkg::cfg_type cfg_ff;
   mcdt_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (mcdt_pkg::csr_index_type'(csr_index))
            mcdt_pkg::CSR_TICKS_PER_SECOND: begin
               cfg_in.ticks_per_second = csr_wdata[15:0];
            end
            mcdt_pkg::CSR_IDLE_POWERDOWN_TICKS: begin
               cfg_in.idle_powerdown_ticks = csr_wdata;
            end
            mcdt_pkg::CSR_ALARM_INTERVAL_TICKS: begin
               cfg_in.alarm_interval_ticks = csr_wdata;
            end
            mcdt_pkg::CSR_ALARM_LIMIT: begin
               cfg_in.alarm_limit = csr_wdata[15:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second     <= mcdt_pkg::TPS_RESET;
         cfg_ff.idle_powerdown_ticks <= mcdt_pkg::IDLE_RESET;
         cfg_ff.alarm_interval_ticks <= mcdt_pkg::ALARM_IV_RESET;
         cfg_ff.alarm_limit          <= mcdt_pkg::ALARM_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mcdt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcdt_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mcdt_pkg::cfg_type   cfg,
   input  wire logic                step_en,
   input  wire mcdt_pkg::req_type   item,
   output mcdt_pkg::rsp_type        result
);

   logic [31:0]        now_ff, now_in;
   logic [31:0]        deadline_ff, deadline_in;
   logic [3:0]         digits_ff [4];
   logic [3:0]         digits_in [4];
   logic [1:0]         cursor_ff, cursor_in;
   mcdt_pkg::mode_type mode_ff, mode_in;
   logic [15:0]        alarm_count_ff, alarm_count_in;
   logic               mark_ff, mark_in;
   logic               sound_ff, sound_in;

   logic [4:0]  btn;
   logic        expired;
   logic [31:0] idle_sum, tps_sum, alarm_sum, dl_tps, dl_alarm;
   logic [15:0] count_inc;
   logic        borrow_done;

   // time base and deadline candidates, time frozen once powered down
   always_comb begin
      btn       = item.kind ? item.buttons : 5'd0;
      now_in    = (mode_ff == mcdt_pkg::MODE_DOWN) ? now_ff :
                  now_ff + {31'd0, ~item.kind};
      expired   = now_in >= deadline_ff;
      idle_sum  = now_in + {8'd0, cfg.idle_powerdown_ticks};
      tps_sum   = now_in + {16'd0, cfg.ticks_per_second};
      alarm_sum = now_in + {8'd0, cfg.alarm_interval_ticks};
      dl_tps    = deadline_ff + {16'd0, cfg.ticks_per_second};
      dl_alarm  = deadline_ff + {8'd0, cfg.alarm_interval_ticks};
      count_inc = alarm_count_ff + 16'd1;
   end

   // mode update for one word
   always_comb begin
      deadline_in    = deadline_ff;
      digits_in      = digits_ff;
      cursor_in      = cursor_ff;
      mode_in        = mode_ff;
      alarm_count_in = alarm_count_ff;
      mark_in        = mark_ff;
      sound_in       = sound_ff;
      borrow_done    = 1'b0;
      case (mode_ff)
         mcdt_pkg::MODE_IDLE: begin
            if (btn == 5'd0) begin
               if (expired) begin
                  mode_in = mcdt_pkg::MODE_DOWN;
               end
            end else begin
               // cursor moves first, then the digit under the new cursor
               if (btn[mcdt_pkg::BTN_RIGHT] && cursor_in != 2'd0) begin
                  cursor_in = cursor_in - 2'd1;
               end
               if (btn[mcdt_pkg::BTN_LEFT] && cursor_in != mcdt_pkg::CURSOR_MAX) begin
                  cursor_in = cursor_in + 2'd1;
               end
               if (btn[mcdt_pkg::BTN_UP] &&
                   digits_in[cursor_in] < mcdt_pkg::digit_limit(cursor_in)) begin
                  digits_in[cursor_in] = digits_in[cursor_in] + 4'd1;
               end
               if (btn[mcdt_pkg::BTN_DOWN] && digits_in[cursor_in] != 4'd0) begin
                  digits_in[cursor_in] = digits_in[cursor_in] - 4'd1;
               end
               if (btn[3:0] != 4'd0) begin
                  deadline_in = idle_sum;
               end
               if (btn[mcdt_pkg::BTN_CENTER]) begin
                  if ((digits_in[0] | digits_in[1] | digits_in[2] | digits_in[3]) != 4'd0)
                  begin
                     mode_in     = mcdt_pkg::MODE_COUNT;
                     deadline_in = tps_sum;
                  end else begin
                     mode_in     = mcdt_pkg::MODE_ALARM;
                     deadline_in = alarm_sum;
                     mark_in     = 1'b1;
                     sound_in    = ~sound_ff;
                  end
               end
            end
         end
         mcdt_pkg::MODE_COUNT: begin
            if (btn != 5'd0) begin
               mode_in     = mcdt_pkg::MODE_IDLE;
               deadline_in = idle_sum;
               for (int i = 0; i < 4; i++) begin
                  digits_in[i] = 4'd0;
               end
            end else if (expired) begin
               // bcd borrow: zero digits wrap to their limit
               for (int i = 0; i < 4; i++) begin
                  if (!borrow_done) begin
                     if (digits_in[i] != 4'd0) begin
                        digits_in[i] = digits_in[i] - 4'd1;
                        borrow_done  = 1'b1;
                     end else begin
                        digits_in[i] = mcdt_pkg::digit_limit(2'(i));
                     end
                  end
               end
               if ((digits_in[0] | digits_in[1] | digits_in[2] | digits_in[3]) != 4'd0)
               begin
                  deadline_in = dl_tps;
               end else begin
                  mode_in     = mcdt_pkg::MODE_ALARM;
                  deadline_in = alarm_sum;
                  mark_in     = 1'b1;
                  sound_in    = ~sound_ff;
               end
            end
         end
         mcdt_pkg::MODE_ALARM: begin
            if (btn != 5'd0) begin
               mode_in        = mcdt_pkg::MODE_IDLE;
               deadline_in    = idle_sum;
               mark_in        = 1'b0;
               sound_in       = 1'b0;
               alarm_count_in = 16'd0;
            end else if (expired) begin
               alarm_count_in = count_inc;
               if (count_inc >= cfg.alarm_limit) begin
                  mode_in = mcdt_pkg::MODE_DOWN;
               end else begin
                  mark_in     = 1'b1;
                  sound_in    = ~sound_ff;
                  deadline_in = dl_alarm;
               end
            end
         end
         default: begin
            // powered down: everything frozen until reset
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= 32'd0;
         deadline_ff    <= {8'd0, mcdt_pkg::IDLE_RESET};
         for (int i = 0; i < 4; i++) begin
            digits_ff[i] <= 4'd0;
         end
         cursor_ff      <= mcdt_pkg::CURSOR_RESET;
         mode_ff        <= mcdt_pkg::MODE_IDLE;
         alarm_count_ff <= 16'd0;
         mark_ff        <= 1'b0;
         sound_ff       <= 1'b0;
      end else if (step_en) begin
         now_ff         <= now_in;
         deadline_ff    <= deadline_in;
         digits_ff      <= digits_in;
         cursor_ff      <= cursor_in;
         mode_ff        <= mode_in;
         alarm_count_ff <= alarm_count_in;
         mark_ff        <= mark_in;
         sound_ff       <= sound_in;
      end
   end

   // result word shows the state after this item
   always_comb begin
      result.sec_units    = digits_in[0];
      result.sec_tens     = digits_in[1][2:0];
      result.min_units    = digits_in[2];
      result.min_tens     = digits_in[3][2:0];
      result.cursor_pos   = cursor_in;
      result.cursor_shown = mode_in == mcdt_pkg::MODE_IDLE;
      result.mode         = mode_in;
      result.alarm_flag   = mark_in;
      result.alarm_sound  = sound_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mmss_countdown_timer_controller_core.sv =====
// mm:ss countdown timer controller
// req channel: one word per event, kind 0 is one tick, kind 1 carries a
// button mask (right, left, up, down, center, handled in that order).
// rsp channel: exactly one word per req word, holding the digits, cursor,
// mode and alarm indicators after that event.
// csr port: four registers written with csr_write_en, csr_index and
// csr_wdata; write them only while no word is in flight.
// path: the accepting edge loads the input register, and the state update
// is stored in the result register, raising rsp_valid, once that register
// is empty or being read.
// throughput: one word per cycle while rsp is taken; the state update is a
// single pass of logic, so each word sees the state left by the one before.
// reset: registers return to 1000, 60000, 500 and 120, time to zero,
// digits cleared, cursor on the minutes units digit, idle mode.
// stall: while rsp is held, the input register still takes one more word;
// req_ready drops only when both the input and result registers are full.
// powered down mode ignores every event until reset but still answers.
`timescale 1ns / 1ps
`default_nettype none
`include "mmss_countdown_timer_controller_core_defines.svh"

module mmss_countdown_timer_controller_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire mcdt_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output mcdt_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [mcdt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mcdt_pkg::cfg_type cfg;
   mcdt_pkg::rsp_type step_result;

   logic              in_valid_ff, in_valid_in;
   mcdt_pkg::req_type in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   mcdt_pkg::rsp_type rsp_data_ff;
   logic              advance;

   mcdt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mcdt_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   // handshake control
   always_comb begin
      advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready   = !in_valid_ff || advance;
      in_valid_in = (req_valid && req_ready) ? 1'b1 :
                    (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MCDT_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid_ff,
      "processed word did not reach the result register")
   `MCDT_ASSERT_NEXT(a_held_word_waits, in_valid_ff && !advance,
      in_valid_ff && $stable(in_data_ff), "waiting input word was lost or changed")
   `MCDT_ASSERT_SAME(a_cursor_shown_idle, rsp_valid_ff,
      rsp_data_ff.cursor_shown == (rsp_data_ff.mode == mcdt_pkg::MODE_IDLE),
      "cursor_shown disagrees with mode")
   `MCDT_ASSERT_SAME(a_digit_range, rsp_valid_ff,
      rsp_data_ff.sec_units <= mcdt_pkg::UNITS_MAX &&
      rsp_data_ff.min_units <= mcdt_pkg::UNITS_MAX &&
      {1'b0, rsp_data_ff.sec_tens} <= mcdt_pkg::TENS_MAX &&
      {1'b0, rsp_data_ff.min_tens} <= mcdt_pkg::TENS_MAX,
      "digit out of range")
   `MCDT_ASSERT_NEXT(a_powerdown_sticks,
      rsp_valid_ff && rsp_data_ff.mode == mcdt_pkg::MODE_DOWN,
      rsp_data_ff.mode == mcdt_pkg::MODE_DOWN, "left powered down mode without reset")

endmodule

`default_nettype wire
